[sv/message_fifo_with_search_top_macros.svh]
// Assertion macros for the message FIFO with search.
`ifndef MESSAGE_FIFO_WITH_SEARCH_TOP_MACROS_SVH
`define MESSAGE_FIFO_WITH_SEARCH_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define MFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mfs_pkg.sv]
// Shared types and constants for the message FIFO with search.
package mfs_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CMD_W = 2;
  localparam int SRC_W = 16;
  localparam int MSG_W = 32;
  localparam int OCC_W = 5;
  localparam int TOT_W = 32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd3;

  // One result beat as it leaves the controller.
  typedef struct packed {
    logic                    success;
    logic                    full_drop;
    logic [SRC_W-1:0]        out_source;
    logic signed [MSG_W-1:0] out_message;
    logic [OCC_W-1:0]        occupancy;
    logic [TOT_W-1:0]        enqueued_total;
    logic [TOT_W-1:0]        dequeued_total;
  } res_t;

endpackage

[sv/message_fifo_with_search_top.sv]
// Message FIFO with search: enqueue and flush go straight to the result state, dequeue
// reads the head entry first, and a search compares entries up to and including the oldest
// match (at most occupancy, none when empty), one entry per cycle through the RAM read port.
// A finished result waits in the result state while the output register is stalled.
// The result stays in an output register while the next item is taken.
// Synchronous rst clears pointers, count, totals and valids; RAM contents are kept.
module message_fifo_with_search_top #(
  parameter int QUEUE_DEPTH = mfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mfs_pkg::CMD_W-1:0]        command,
  input  logic [mfs_pkg::SRC_W-1:0]        source_id,
  input  logic signed [mfs_pkg::MSG_W-1:0] message,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             success,
  output logic                             full_drop,
  output logic [mfs_pkg::SRC_W-1:0]        out_source,
  output logic signed [mfs_pkg::MSG_W-1:0] out_message,
  output logic [mfs_pkg::OCC_W-1:0]        occupancy,
  output logic [mfs_pkg::TOT_W-1:0]        enqueued_total,
  output logic [mfs_pkg::TOT_W-1:0]        dequeued_total
);

  `include "message_fifo_with_search_top_macros.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int DW = mfs_pkg::SRC_W + mfs_pkg::MSG_W;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  mfs_pkg::res_t res;
  mfs_pkg::res_t out_res;
  logic          res_valid;
  logic          res_take;
  logic          accept;

  // Entry storage: source and message side by side.
  mfs_ram #(
    .WIDTH(DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mfs_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .source_id(source_id),
    .message  (message),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .res      (res),
    .res_valid(res_valid),
    .res_take (res_take),
    .accept   (accept)
  );

  // Output register loads when empty or when its beat leaves this cycle.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign success        = out_res.success;
  assign full_drop      = out_res.full_drop;
  assign out_source     = out_res.out_source;
  assign out_message    = out_res.out_message;
  assign occupancy      = out_res.occupancy;
  assign enqueued_total = out_res.enqueued_total;
  assign dequeued_total = out_res.dequeued_total;

  // The sequencer works on one item at a time.
  `MFS_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "input taken while item in flight")
  // A result handed to the output register is not offered twice.
  `MFS_ASSERT_NEXT(a_result_once, res_take, !res_valid, "result offered twice")
  // A dropped enqueue never reports success.
  `MFS_ASSERT_NOW(a_drop_no_success, out_valid && full_drop, !success, "drop with success")

endmodule

[sv/mfs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mfs_ctrl.sv]
// Command sequencer: queue pointers, counters and the search scan over the RAM.
module mfs_ctrl #(
  parameter int QUEUE_DEPTH = mfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mfs_pkg::CMD_W-1:0]              command,
  input  logic [mfs_pkg::SRC_W-1:0]              source_id,
  input  logic signed [mfs_pkg::MSG_W-1:0]       message,
  output logic                                   ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]         ram_waddr,
  output logic [mfs_pkg::SRC_W+mfs_pkg::MSG_W-1:0] ram_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0]         ram_raddr,
  input  logic [mfs_pkg::SRC_W+mfs_pkg::MSG_W-1:0] ram_rdata,
  output mfs_pkg::res_t                          res,
  output logic                                   res_valid,
  input  logic                                   res_take,
  output logic                                   accept
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0]                       state;
  logic [AW-1:0]                    head;
  logic [AW-1:0]                    tail;
  logic [CW-1:0]                    count;
  logic [mfs_pkg::TOT_W-1:0]        enq_cnt;
  logic [mfs_pkg::TOT_W-1:0]        deq_cnt;
  logic [AW-1:0]                    scan_ptr;
  logic [CW-1:0]                    scan_k;
  logic [mfs_pkg::MSG_W-1:0]        key;
  logic                             r_success;
  logic                             r_drop;
  logic [mfs_pkg::SRC_W-1:0]        r_src;
  logic [mfs_pkg::MSG_W-1:0]        r_msg;

  logic                             full;
  logic                             empty;
  logic                             match;
  logic                             scan_last;
  logic [mfs_pkg::SRC_W-1:0]        rd_src;
  logic [mfs_pkg::MSG_W-1:0]        rd_msg;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  // Handshake and status decode.
  assign in_stall  = rst || (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign rd_src    = ram_rdata[mfs_pkg::SRC_W+mfs_pkg::MSG_W-1:mfs_pkg::MSG_W];
  assign rd_msg    = ram_rdata[mfs_pkg::MSG_W-1:0];
  assign match     = (rd_msg == key);
  assign scan_last = ((scan_k + 1'b1) == count);

  // RAM access: write on an accepted enqueue that finds room, read the head or the scan pointer.
  assign ram_we    = accept && (command == mfs_pkg::CMD_ENQUEUE) && !full;
  assign ram_waddr = tail;
  assign ram_wdata = {source_id, message};
  assign ram_raddr = (state == ST_SCAN) ? scan_ptr : head;

  // Sequencer, pointers and running counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      enq_cnt <= '0;
      deq_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              mfs_pkg::CMD_ENQUEUE: begin
                state <= ST_RESULT;
                if (!full) begin
                  tail    <= next_idx(tail);
                  count   <= count + 1'b1;
                  enq_cnt <= enq_cnt + 1'b1;
                end
              end
              mfs_pkg::CMD_DEQUEUE: begin
                if (!empty) begin
                  head    <= next_idx(head);
                  count   <= count - 1'b1;
                  deq_cnt <= deq_cnt + 1'b1;
                  state   <= ST_READ;
                end else begin
                  state   <= ST_RESULT;
                end
              end
              mfs_pkg::CMD_SEARCH: begin
                if (!empty) begin
                  scan_ptr <= next_idx(head);
                  scan_k   <= '0;
                  state    <= ST_SCAN;
                end else begin
                  state    <= ST_RESULT;
                end
              end
              default: begin
                state   <= ST_RESULT;
                head    <= '0;
                tail    <= '0;
                count   <= '0;
                enq_cnt <= '0;
                deq_cnt <= '0;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_RESULT;
        end
        ST_SCAN: begin
          if (match || scan_last) begin
            state <= ST_RESULT;
          end else begin
            scan_ptr <= next_idx(scan_ptr);
            scan_k   <= scan_k + 1'b1;
          end
        end
        default: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

  // Result payload and search key.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      key       <= message;
      r_success <= (command == mfs_pkg::CMD_ENQUEUE) && !full;
      r_drop    <= (command == mfs_pkg::CMD_ENQUEUE) && full;
      r_src     <= '0;
      r_msg     <= '0;
    end else if (state == ST_READ) begin
      r_success <= 1'b1;
      r_src     <= rd_src;
      r_msg     <= rd_msg;
    end else if (state == ST_SCAN && match) begin
      r_success <= 1'b1;
      r_src     <= rd_src;
    end
  end

  // Result beat toward the output register.
  assign res_valid          = (state == ST_RESULT);
  assign res.success        = r_success;
  assign res.full_drop      = r_drop;
  assign res.out_source     = r_src;
  assign res.out_message    = r_msg;
  assign res.occupancy      = mfs_pkg::OCC_W'(count);
  assign res.enqueued_total = enq_cnt;
  assign res.dequeued_total = deq_cnt;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the message FIFO with search, with a queue model as scoreboard.
`timescale 1ns / 1ps

// Tracks the queue contents and running totals, and keeps the replies still to come.
class queue_tracker;
  logic [15:0]   held_source[$];
  logic [31:0]   held_message[$];
  logic [31:0]   enq_total;
  logic [31:0]   deq_total;
  mfs_pkg::res_t pending_replies[$];
  int            mismatches;

  function new();
    enq_total  = '0;
    deq_total  = '0;
    mismatches = 0;
  endfunction

  // Applies one accepted command to the model and queues the reply it must produce.
  function void note_command(logic [1:0] cmd, logic [15:0] src, logic [31:0] msg);
    mfs_pkg::res_t reply;
    bit            found;
    reply = '0;
    found = 1'b0;
    case (cmd)
      mfs_pkg::CMD_ENQUEUE: begin
        if (held_source.size() >= mfs_pkg::QUEUE_DEPTH_DEF) begin
          reply.full_drop = 1'b1;
        end else begin
          held_source.push_back(src);
          held_message.push_back(msg);
          enq_total++;
          reply.success = 1'b1;
        end
      end
      mfs_pkg::CMD_DEQUEUE: begin
        if (held_source.size() != 0) begin
          reply.out_source  = held_source.pop_front();
          reply.out_message = held_message.pop_front();
          deq_total++;
          reply.success = 1'b1;
        end
      end
      mfs_pkg::CMD_SEARCH: begin
        // The oldest matching entry wins.
        for (int i = 0; i < held_message.size() && !found; i++) begin
          if (held_message[i] == msg) begin
            reply.out_source = held_source[i];
            reply.success    = 1'b1;
            found            = 1'b1;
          end
        end
      end
      mfs_pkg::CMD_FLUSH: begin
        held_source.delete();
        held_message.delete();
        enq_total = '0;
        deq_total = '0;
      end
      default: begin
      end
    endcase
    reply.occupancy      = mfs_pkg::OCC_W'(held_source.size());
    reply.enqueued_total = enq_total;
    reply.dequeued_total = deq_total;
    pending_replies.push_back(reply);
  endfunction

  function void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  // Compares one accepted reply beat with the oldest expected reply.
  function void check_reply(mfs_pkg::res_t got);
    mfs_pkg::res_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply beat, expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = pending_replies.pop_front();
    check_field("success", 32'(want.success), 32'(got.success));
    check_field("full_drop", 32'(want.full_drop), 32'(got.full_drop));
    check_field("out_source", 32'(want.out_source), 32'(got.out_source));
    check_field("out_message", want.out_message, got.out_message);
    check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    check_field("enqueued_total", want.enqueued_total, got.enqueued_total);
    check_field("dequeued_total", want.dequeued_total, got.dequeued_total);
  endfunction
endclass

module tb_top;

  localparam int DEPTH        = mfs_pkg::QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AFTER   = 150;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_SEARCH} traffic_mix_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [mfs_pkg::CMD_W-1:0]        command;
  logic [mfs_pkg::SRC_W-1:0]        source_id;
  logic signed [mfs_pkg::MSG_W-1:0] message;
  logic                             out_valid;
  logic                             out_stall;
  logic                             success;
  logic                             full_drop;
  logic [mfs_pkg::SRC_W-1:0]        out_source;
  logic signed [mfs_pkg::MSG_W-1:0] out_message;
  logic [mfs_pkg::OCC_W-1:0]        occupancy;
  logic [mfs_pkg::TOT_W-1:0]        enqueued_total;
  logic [mfs_pkg::TOT_W-1:0]        dequeued_total;

  queue_tracker tracker = new();
  int           items_accepted = 0;
  int           cycle_count;
  bit           sender_idle_on = 1'b1;
  bit           receiver_idle_on = 1'b1;
  bit           quiet_tail = 1'b0;
  bit           hold_done = 1'b0;

  message_fifo_with_search_top #(
    .QUEUE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .source_id(source_id),
    .message(message),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .success(success),
    .full_drop(full_drop),
    .out_source(out_source),
    .out_message(out_message),
    .occupancy(occupancy),
    .enqueued_total(enqueued_total),
    .dequeued_total(dequeued_total)
  );

  always #2 clk = ~clk;

  // Offers one command beat, with an optional idle burst first, and waits for acceptance.
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] src,
                           input logic [31:0] msg);
    if (sender_idle_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    command   <= cmd;
    source_id <= src;
    message   <= msg;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.note_command(cmd, src, msg);
    items_accepted++;
  endtask

  // Messages come often from a small set so that searches hit and duplicates occur.
  function automatic logic [31:0] pick_message();
    if ($urandom_range(0, 9) < 4) begin
      case ($urandom_range(0, 7))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        3:       return 32'h7FFF_FFFF;
        4:       return 32'h5555_5555;
        5:       return 32'hAAAA_AAAA;
        6:       return 32'h0000_0001;
        default: return 32'h0000_0007;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_command(input traffic_mix_t mix);
    int roll;
    int enq_pct;
    int deq_pct;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:     begin enq_pct = 75; deq_pct = 10; end
      MIX_DRAIN:    begin enq_pct = 15; deq_pct = 70; end
      MIX_BALANCED: begin enq_pct = 35; deq_pct = 30; end
      default:      begin enq_pct = 25; deq_pct = 15; end
    endcase
    if (roll < 2) return mfs_pkg::CMD_FLUSH;
    if (roll < 2 + enq_pct) return mfs_pkg::CMD_ENQUEUE;
    if (roll < 2 + enq_pct + deq_pct) return mfs_pkg::CMD_DEQUEUE;
    return mfs_pkg::CMD_SEARCH;
  endfunction

  // Corner values, both search outcomes, and a flush with stale entries left in storage.
  task automatic run_directed();
    send_item(mfs_pkg::CMD_DEQUEUE, 16'h0000, 32'h0000_0000);
    send_item(mfs_pkg::CMD_SEARCH,  16'hFFFF, 32'h0000_0000);
    send_item(mfs_pkg::CMD_ENQUEUE, 16'h0000, 32'h8000_0000);
    send_item(mfs_pkg::CMD_ENQUEUE, 16'hFFFF, 32'h7FFF_FFFF);
    send_item(mfs_pkg::CMD_ENQUEUE, 16'h1234, 32'h0000_0000);
    send_item(mfs_pkg::CMD_ENQUEUE, 16'h0005, 32'h7FFF_FFFF);
    send_item(mfs_pkg::CMD_ENQUEUE, 16'hABCD, 32'hFFFF_FFFF);
    // Two entries match; the older one must be reported.
    send_item(mfs_pkg::CMD_SEARCH,  16'h0000, 32'h7FFF_FFFF);
    send_item(mfs_pkg::CMD_SEARCH,  16'h0000, 32'h0000_0001);
    send_item(mfs_pkg::CMD_SEARCH,  16'h0000, 32'hFFFF_FFFF);
    send_item(mfs_pkg::CMD_DEQUEUE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(mfs_pkg::CMD_DEQUEUE, 16'h0000, 32'h0000_0000);
    send_item(mfs_pkg::CMD_FLUSH,   16'hFFFF, 32'hFFFF_FFFF);
    send_item(mfs_pkg::CMD_DEQUEUE, 16'h0000, 32'h0000_0000);
    // Storage still holds old data, but nothing is held after the flush.
    send_item(mfs_pkg::CMD_SEARCH,  16'h0000, 32'h0000_0000);
    send_item(mfs_pkg::CMD_ENQUEUE, 16'h00FF, 32'h0000_FFFF);
  endtask

  // Random traffic in blocks, each with its own command mix and idling choice.
  task automatic run_random(input int count);
    traffic_mix_t mix;
    logic [1:0]   cmd;
    logic [15:0]  src;
    logic [31:0]  msg;
    mix = MIX_BALANCED;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) begin
        mix            = traffic_mix_t'($urandom_range(0, 3));
        sender_idle_on = ($urandom_range(0, 2) != 0);
      end
      if (i == count - 60) quiet_tail = 1'b1;
      cmd = pick_command(mix);
      case ($urandom_range(0, 7))
        0:       src = 16'h0000;
        1:       src = 16'hFFFF;
        default: src = 16'($urandom_range(0, 65535));
      endcase
      if (cmd == mfs_pkg::CMD_SEARCH && tracker.held_message.size() != 0 &&
          $urandom_range(0, 1)) begin
        msg = tracker.held_message[$urandom_range(0, tracker.held_message.size() - 1)];
      end else begin
        msg = pick_message();
      end
      send_item(cmd, src, msg);
    end
  endtask

  // Receiver stall: random bursts, one long hold-off, and none in the final stretch.
  initial begin
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!hold_done && items_accepted >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet_tail && receiver_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 39) == 0) receiver_idle_on = !receiver_idle_on;
    end
  end

  // Every accepted reply beat is checked against the oldest expectation.
  always @(posedge clk) begin : reply_monitor
    mfs_pkg::res_t got;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      got.success        = success;
      got.full_drop      = full_drop;
      got.out_source     = out_source;
      got.out_message    = out_message;
      got.occupancy      = occupancy;
      got.enqueued_total = enqueued_total;
      got.dequeued_total = dequeued_total;
      tracker.check_reply(got);
    end
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence: reset, directed items, random items, then drain.
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = mfs_pkg::CMD_ENQUEUE;
    source_id = '0;
    message   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(RANDOM_ITEMS);
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
